FILE: sv/wpam_pkg.sv
// ---------------------------------------------------------------------------
// wpam_pkg: shared types and constants for the wildcard pattern matcher
// Beat structs for both channels, the config port format and the register
// index codes.
// ---------------------------------------------------------------------------
package wpam_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PLEN_W     = 6;
  localparam int ADDR_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_WORD_0  = 3'd0,
    REG_PAT_WORD_1  = 3'd1,
    REG_PAT_WORD_2  = 3'd2,
    REG_PAT_WORD_3  = 3'd3,
    REG_CARE_MASK   = 3'd4,
    REG_PAT_LENGTH  = 3'd5,
    REG_REGION_BASE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic              region_done;
  } out_beat_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic shift;  // a byte is taken this cycle
    logic clear;  // region ends with this byte
  } chain_ctl_t;

endpackage

FILE: sv/wpam_cell.sv
// ---------------------------------------------------------------------------
// wpam_cell: one pattern position of the match chain
// Holds whether pattern bytes 0..i matched the bytes ending at the previous
// beat and hands that flag to the next cell.
// ---------------------------------------------------------------------------
module wpam_cell (
  input  logic                clk,
  input  logic                rst,
  input  wpam_pkg::chain_ctl_t ctl,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          pat_byte,
  input  logic                care,
  input  logic                prev_hit,
  output logic                hit_next,
  output logic                hit
);
  import wpam_pkg::*;

  assign hit_next = prev_hit && (!care || (data_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.shift) begin
      hit <= ctl.clear ? 1'b0 : hit_next;
    end
  end

endmodule

FILE: sv/wpam_chain.sv
// ---------------------------------------------------------------------------
// wpam_chain: row of match cells
// Cell i tracks a partial match of pattern bytes 0..i; the cell chosen by the
// pattern length reports a full match ending at the current byte.
// ---------------------------------------------------------------------------
module wpam_chain #(
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wpam_pkg::chain_ctl_t                ctl,
  input  logic [7:0]                          data_byte,
  input  logic [MAX_PATTERN_LEN-1:0][7:0]     pat_bytes,
  input  logic [MAX_PATTERN_LEN-1:0]          care_bits,
  input  logic [$clog2(MAX_PATTERN_LEN)-1:0]  last_pos,
  output logic                                found
);
  import wpam_pkg::*;

  logic [MAX_PATTERN_LEN-1:0] hit;
  logic [MAX_PATTERN_LEN-1:0] hit_next;
  logic [MAX_PATTERN_LEN-1:0] prev_hit;

  assign prev_hit = {hit[MAX_PATTERN_LEN-2:0], 1'b1};

  for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_cell
    wpam_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .data_byte (data_byte),
      .pat_byte  (pat_bytes[i]),
      .care      (care_bits[i]),
      .prev_hit  (prev_hit[i]),
      .hit_next  (hit_next[i]),
      .hit       (hit[i])
    );
  end

  assign found = hit_next[last_pos];

endmodule

FILE: sv/wildcard_pattern_all_matches_core.sv
// ---------------------------------------------------------------------------
// wildcard_pattern_all_matches_core: masked byte pattern scanner
// Reports every start address at which a wildcard pattern matches within a
// streamed memory region, and flags the end of each region.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one region byte per
//   beat, with last_byte set on the final byte of the region.
//   Output channel (out_valid / out_stall / out_data) carries a beat for each
//   byte that completes a match or ends a region; other bytes give no beat.
//   The user must write the config port (cfg_we / cfg_index / cfg_data) only
//   while the block is idle; the block does not enforce this. Index 7 is ignored.
// Timing:
//   One byte per cycle sustained while the input is not stalled. A result beat
//   passes stage 1, which registers the cell chain match and start offset, then
//   the output register, which holds the 64-bit base add.
// Stall:
//   A stalled output beat holds; the input stalls only when the middle stage
//   is also full and cannot move, so a finished result and a new byte can
//   coexist.
// Reset:
//   Clears the match chain, the offset and both stages; pattern registers go
//   to zero, care mask to zero, length to one.
// ---------------------------------------------------------------------------
module wildcard_pattern_all_matches_core #(
  parameter int MAX_PATTERN_LEN = 32,
  parameter int OFFSET_BITS     = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [wpam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpam_pkg::CFG_DATA_W-1:0]     cfg_data,
  // byte stream in
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wpam_pkg::in_beat_t                  in_data,
  // results out
  output logic                                out_valid,
  input  logic                                out_stall,
  output wpam_pkg::out_beat_t                 out_data
);
  import wpam_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN_LEN);
  localparam logic [PLEN_W-1:0] MAX_LEN = PLEN_W'(MAX_PATTERN_LEN);

  // config registers
  logic [PAT_WORDS-1:0][63:0] pat_words;
  logic [31:0]                care_mask;
  logic [PLEN_W-1:0]          pat_length;
  logic [ADDR_W-1:0]          region_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_words   <= '0;
      care_mask   <= '0;
      pat_length  <= PLEN_W'(1);
      region_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_WORD_0:  pat_words[0] <= cfg_data;
        REG_PAT_WORD_1:  pat_words[1] <= cfg_data;
        REG_PAT_WORD_2:  pat_words[2] <= cfg_data;
        REG_PAT_WORD_3:  pat_words[3] <= cfg_data;
        REG_CARE_MASK:   care_mask    <= cfg_data[31:0];
        REG_PAT_LENGTH:  pat_length   <= cfg_data[PLEN_W-1:0];
        REG_REGION_BASE: region_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pattern bytes, byte 0 in the low bits of word 0
  logic [PAT_BYTES-1:0][7:0] pat_bytes;
  assign pat_bytes = pat_words;

  // effective length: zero acts as one, clamp at the chain length
  logic [PLEN_W-1:0] eff_len;
  logic [LW-1:0]     last_pos;  // eff_len - 1, the cell that reports a match

  always_comb begin
    if (pat_length == '0) begin
      eff_len = PLEN_W'(1);
    end else if (pat_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = pat_length;
    end
  end

  assign last_pos = LW'(eff_len - PLEN_W'(1));

  // handshake and pipeline control
  logic accept;
  logic s2_load;
  logic s1_valid;
  logic s1_found;
  logic s1_last;
  logic [OFFSET_BITS-1:0] s1_start;
  chain_ctl_t ctl;
  logic found;

  assign s2_load  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_load;
  assign accept   = in_valid && !in_stall;

  assign ctl.shift = accept;
  assign ctl.clear = in_data.last_byte;

  wpam_chain #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .data_byte (in_data.data_byte),
    .pat_bytes (pat_bytes[MAX_PATTERN_LEN-1:0]),
    .care_bits (care_mask[MAX_PATTERN_LEN-1:0]),
    .last_pos  (last_pos),
    .found     (found)
  );

  // offset of the current byte within the region, saturating
  logic [OFFSET_BITS-1:0] byte_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        byte_offset <= '0;
      end else if (byte_offset != '1) begin
        byte_offset <= byte_offset + OFFSET_BITS'(1);
      end
    end
  end

  // stage 1: match flag and start offset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= found || in_data.last_byte;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_found <= found;
      s1_last  <= in_data.last_byte;
      s1_start <= byte_offset - OFFSET_BITS'(last_pos);
    end
  end

  // stage 2: base add into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_data.match_found   <= s1_found;
      out_data.region_done   <= s1_last;
      out_data.match_address <= s1_found ? region_base + ADDR_W'(s1_start) : '0;
    end
  end

  // checks
  a_offset_clear: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_byte |=> byte_offset == '0)
    else $error("offset not cleared after region end");

  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    accept && !in_data.last_byte && byte_offset != '1
      |=> byte_offset == $past(byte_offset) + OFFSET_BITS'(1))
    else $error("offset did not advance");

  a_out_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.match_found || out_data.region_done)
    else $error("result beat with neither match nor region end");

  a_no_match_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.match_found |-> out_data.match_address == '0)
    else $error("address set on a beat without a match");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/match_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// match_scoreboard_pkg: prediction and checking for the pattern scanner bench
// Keeps a bit-exact copy of the scanner state and register file, turns each
// accepted byte into the report it should cause, and checks the output beats
// against those reports in order.
// ---------------------------------------------------------------------------
package match_scoreboard_pkg;

  import wpam_pkg::*;

  localparam int HIST_DEPTH = PAT_BYTES - 1;
  localparam int OFFS_W     = 32;
  localparam int SHOW_ERRS  = 10;

  class match_scoreboard;
    logic [CFG_DATA_W-1:0] pat_word [PAT_WORDS];
    logic [PAT_BYTES-1:0]  care_mask;
    logic [PLEN_W-1:0]     pat_len;
    logic [ADDR_W-1:0]     base_addr;
    logic [7:0]            history [HIST_DEPTH];
    logic [OFFS_W-1:0]     offset;
    out_beat_t             pending_reports [$];
    int n_bytes, n_regions, n_matches, n_checked, n_errors;

    function new();
      foreach (pat_word[k]) pat_word[k] = '0;
      foreach (history[k]) history[k] = '0;
      care_mask = '0;
      pat_len   = 1;
      base_addr = '0;
      offset    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_PAT_WORD_0:  pat_word[0] = d;
        REG_PAT_WORD_1:  pat_word[1] = d;
        REG_PAT_WORD_2:  pat_word[2] = d;
        REG_PAT_WORD_3:  pat_word[3] = d;
        REG_CARE_MASK:   care_mask   = d[PAT_BYTES-1:0];
        REG_PAT_LENGTH:  pat_len     = d[PLEN_W-1:0];
        REG_REGION_BASE: base_addr   = d;
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the array acts as full length
    function int unsigned eff_len();
      if (pat_len == 0) return 1;
      if (pat_len > PAT_BYTES) return PAT_BYTES;
      return pat_len;
    endfunction

    function logic [7:0] pat_byte(int unsigned i);
      return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function bit window_hit(logic [7:0] cur, int unsigned len);
      logic [7:0] d;
      for (int unsigned i = 0; i < len; i++) begin
        if (!care_mask[i]) continue;
        d = (i == len - 1) ? cur : history[len - 2 - i];
        if (d != pat_byte(i)) return 0;
      end
      return 1;
    endfunction

    // advance the scanner by one accepted byte, queue the report it causes
    function void note_byte(in_beat_t b);
      int unsigned len;
      bit          hit;
      out_beat_t   rpt;
      len = eff_len();
      hit = ({32'b0, offset} + 64'd1 >= 64'(len)) && window_hit(b.data_byte, len);
      rpt.match_found   = hit;
      rpt.match_address = hit ? base_addr + ({32'b0, offset} - 64'(len - 1)) : '0;
      rpt.region_done   = b.last_byte;
      n_bytes++;
      if (b.last_byte) begin
        foreach (history[k]) history[k] = '0;
        offset = '0;
        n_regions++;
      end else begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
        history[0] = b.data_byte;
        if (offset != '1) offset++;
      end
      if (hit) n_matches++;
      if (hit || b.last_byte) pending_reports.insert(pending_reports.size(), rpt);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      n_checked++;
      if (pending_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_ERRS)
          $display("ERROR: result beat with nothing pending: found=%0b addr=%h done=%0b",
                   got.match_found, got.match_address, got.region_done);
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
        n_errors++;
        if (n_errors <= SHOW_ERRS)
          $display("ERROR: beat %0d: want found=%0b addr=%h done=%0b, got found=%0b addr=%h done=%0b",
                   n_checked, want.match_found, want.match_address, want.region_done,
                   got.match_found, got.match_address, got.region_done);
      end
    endfunction
  endclass

endpackage

FILE: tb/wildcard_pattern_all_matches_core_tb.sv
// ---------------------------------------------------------------------------
// wildcard_pattern_all_matches_core_tb: self-checking bench for the scanner
// Streams byte regions through the matcher under several pattern settings,
// predicts every match and region-end report, and checks each output beat in
// order while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module wildcard_pattern_all_matches_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpam_pkg::*;
  import match_scoreboard_pkg::*;

  // index 7 is past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 500;
  localparam int SETTLE_CYCLES = 6;   // lets report-free bytes drain after the last report
  localparam int HOLD_CYCLES   = 150;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;

  match_scoreboard sb = new();

  // sender and receiver idling controls
  int  burst_left = 0;
  bit  gaps_on    = 1'b1;
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;
  int  stall_mode = 0;
  int  mode_left  = 0;
  int  cycle_count = 0;
  int  settings_used = 0;
  int  holdoffs_done = 0;

  logic [7:0] region_bytes [$];

  wildcard_pattern_all_matches_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost report ends here.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("ERROR: cycle limit reached with %0d reports pending",
                 sb.pending_reports.size());
        $display("wildcard_pattern_all_matches_core_tb: FAIL");
        $finish;
      end
    end
  end

  // Result side. Every beat taken is checked against the oldest report.
  // Stall behavior switches at random between modes: open, light random,
  // heavy random and toggling. A hold-off request from the sender forces a
  // long solid stall so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(out_data);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
      holdoffs_done++;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // One register write; cfg_we stays up so writes can go back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  // Full register set; optionally a junk write to the unused index too.
  task automatic program_matcher(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                 logic [63:0] w3, logic [31:0] care, logic [5:0] len,
                                 logic [63:0] base, bit poke_spare);
    write_reg(REG_PAT_WORD_0, w0);
    write_reg(REG_PAT_WORD_1, w1);
    write_reg(REG_PAT_WORD_2, w2);
    write_reg(REG_PAT_WORD_3, w3);
    write_reg(REG_CARE_MASK, {32'b0, care});
    write_reg(REG_PAT_LENGTH, {58'b0, len});
    write_reg(REG_REGION_BASE, base);
    if (poke_spare) write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offer one byte and hold it until taken. Valid stays high afterwards so
  // the next byte can follow with no bubble; gaps open only between bursts.
  task automatic send_byte(logic [7:0] d, logic last);
    in_beat_t b;
    b.data_byte = d;
    b.last_byte = last;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
  endtask

  task automatic send_region();
    foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  // Wait for every report, then let any report-free bytes leave the pipe.
  task automatic wait_idle();
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_region(input logic [7:0] bytes [$]);
    region_bytes = bytes;
    send_region();
  endtask

  // Region of noise with pattern copies planted in it. Wildcard positions
  // get random bytes; some copies get one bit flipped as a near miss.
  // Noise leans on pattern bytes so partial windows line up often.
  function automatic void build_region();
    int unsigned len, rlen, p;
    len = sb.eff_len();
    case ($urandom_range(0, 9))
      0:       rlen = $urandom_range(1, len);
      1:       rlen = $urandom_range(len, len + 60);
      default: rlen = $urandom_range(len, 2 * len + 6);
    endcase
    region_bytes.delete();
    repeat (rlen)
      region_bytes.insert(region_bytes.size(),
                          $urandom_range(0, 1) ? 8'($urandom)
                                               : sb.pat_byte($urandom_range(0, len - 1)));
    if (rlen >= len) begin
      repeat ($urandom_range(0, 3)) begin
        p = $urandom_range(0, rlen - len);
        for (int unsigned i = 0; i < len; i++)
          region_bytes[p + i] = sb.care_mask[i] ? sb.pat_byte(i) : 8'($urandom);
        if ($urandom_range(0, 4) == 0)
          region_bytes[p + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
  endfunction

  // Random register set, weighted toward short patterns but hitting the
  // extremes: empty and full masks, lengths 0, 1, 32 and above 32, and
  // bases that wrap.
  task automatic random_config();
    logic [63:0] w [4];
    logic [31:0] care;
    logic [5:0]  len;
    logic [63:0] base;
    foreach (w[k]) begin
      case ($urandom_range(0, 7))
        0:       w[k] = '0;
        1:       w[k] = '1;
        default: w[k] = {$urandom, $urandom};
      endcase
    end
    case ($urandom_range(0, 5))
      0:       care = '0;
      1:       care = '1;
      2:       care = $urandom | $urandom;
      default: care = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       len = 6'd0;
      1:       len = 6'($urandom_range(33, 63));
      2:       len = 6'd32;
      3:       len = 6'd1;
      4:       len = 6'd2;
      default: len = 6'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1 - 64'($urandom_range(0, 40));
      default: base = {$urandom, $urandom};
    endcase
    program_matcher(w[0], w[1], w[2], w[3], care, len, base, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int random_sent;
    int budget;
    int phase_bytes;
    int phase_idx;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PAT_WORD_0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    gaps_on = 1'b0;

    // Reset settings: length one, all wildcards, so every byte matches.
    load_region('{8'h00, 8'hFF});
    in_valid <= 1'b0;
    wait_idle();

    // Four-byte pattern A5 00 ?? 5A, mask bits past the length set, base
    // one below the top so the second match address wraps. The second
    // match ends on the region's last byte.
    program_matcher(64'h0123_4567_5AFF_00A5, '1, '0, 64'hDEAD_BEEF_0000_FFFF,
                    32'hFFFF_FFFB, 6'd4, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    load_region('{8'hA5, 8'h00, 8'h12, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h5A});
    in_valid <= 1'b0;
    wait_idle();

    // Region shorter than the pattern: only the done report.
    gaps_on = 1'b1;
    load_region('{8'hA5, 8'h00, 8'hFF});
    in_valid <= 1'b0;
    wait_idle();

    // Length zero acts as one; junk write to the spare index is ignored.
    program_matcher(64'h0000_0000_0000_0080, '1, '1, '1, 32'h0000_0001, 6'd0,
                    64'h8000_0000_0000_0000, 1'b1);
    load_region('{8'h80, 8'h7F, 8'h80});
    in_valid <= 1'b0;
    wait_idle();

    // Length above the array clamps to 32 with all wildcards: a two-byte
    // region is too short to match anything.
    program_matcher('0, '0, '0, '0, 32'h0, 6'd63, '0, 1'b0);
    load_region('{8'hFF, 8'h00});
    in_valid <= 1'b0;
    wait_idle();

    // ---- random part ----
    random_sent = 0;
    phase_idx   = 0;
    while (random_sent < RANDOM_BYTES) begin
      phase_bytes = 0;
      if (phase_idx == 2) begin
        // Every byte reports; the receiver holds off while bytes keep
        // coming so the pipeline fills and pushes back on the input.
        program_matcher({$urandom, $urandom}, '0, '0, '0, 32'h0, 6'd1,
                        {$urandom, $urandom}, 1'b0);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        region_bytes.delete();
        repeat (40) region_bytes.insert(region_bytes.size(), 8'($urandom));
        send_region();
        phase_bytes = 40;
      end else begin
        random_config();
        gaps_on = ($urandom_range(0, 3) != 0);
        budget  = $urandom_range(30, 80);
        while (phase_bytes < budget) begin
          build_region();
          send_region();
          phase_bytes += region_bytes.size();
        end
      end
      // sender stays quiet until every report is back
      in_valid <= 1'b0;
      wait_idle();
      random_sent += phase_bytes;
      phase_idx++;
    end

    wait_idle();
    $display("Scanned %0d bytes in %0d regions under %0d register settings (%0d hold-offs).",
             sb.n_bytes, sb.n_regions, settings_used, holdoffs_done);
    $display("Checked %0d result beats, %0d of them matches; %0d mismatches.",
             sb.n_checked, sb.n_matches, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_reports.size() == 0) begin
      $display("wildcard_pattern_all_matches_core_tb: PASS");
    end else begin
      $display("wildcard_pattern_all_matches_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/wpam_pkg.sv
sv/wpam_cell.sv
sv/wpam_chain.sv
sv/wildcard_pattern_all_matches_core.sv
tb/match_scoreboard_pkg.sv
tb/wildcard_pattern_all_matches_core_tb.sv
